// ===== hdl/q2e_pkg.sv =====
// Package for the quaternion to Euler angle converter.
// Holds widths, the CORDIC arctangent table and the cell interface types.
// No dependencies.
package q2e_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ANGLE_FRAC_DEF = 7;
  localparam int unsigned ACC_FRAC = 24;
  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned ACC_W = 36;
  localparam int unsigned CW = 38;   // CORDIC x/y datapath width
  localparam int unsigned DIV_W = 34; // divider remainder width
  localparam int unsigned Q_W = 31;   // Q30 quotient incl. one
  localparam int unsigned SQ_W = 62;  // squared argument width

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [CW-1:0] cval_t;

  function automatic acc_t atan_entry(input int unsigned i);
    case (i)
      0: atan_entry = 36'sd754974720;
      1: atan_entry = 36'sd445687602;
      2: atan_entry = 36'sd235489088;
      3: atan_entry = 36'sd119537938;
      4: atan_entry = 36'sd60000934;
      5: atan_entry = 36'sd30029717;
      6: atan_entry = 36'sd15018523;
      7: atan_entry = 36'sd7509720;
      8: atan_entry = 36'sd3754917;
      9: atan_entry = 36'sd1877466;
      10: atan_entry = 36'sd938734;
      11: atan_entry = 36'sd469367;
      12: atan_entry = 36'sd234684;
      13: atan_entry = 36'sd117342;
      14: atan_entry = 36'sd58671;
      15: atan_entry = 36'sd29335;
      16: atan_entry = 36'sd14668;
      17: atan_entry = 36'sd7334;
      18: atan_entry = 36'sd3667;
      19: atan_entry = 36'sd1833;
      20: atan_entry = 36'sd917;
      21: atan_entry = 36'sd458;
      22: atan_entry = 36'sd229;
      23: atan_entry = 36'sd115;
      default: atan_entry = '0;
    endcase
  endfunction

  // One CORDIC vectoring lane as carried between cells
  typedef struct packed {
    cval_t x;
    cval_t y;
    acc_t  acc;
  } lane_t;

endpackage

// ===== hdl/q2e_cordic_cell.sv =====
// Vectoring CORDIC cell: a single micro-rotation per enabled cycle for 3 lanes.
// Depends on q2e_pkg.
module q2e_cordic_cell import q2e_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic  clk,
  input  logic  en,
  input  lane_t lane_i [3],
  output lane_t lane_o [3]
);

  lane_t lane_r [3];
  lane_t lane_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (IDX >= TABLE_LEN) begin
        lane_nxt[k] = lane_i[k];
      end else if (!lane_i[k].y[CW-1]) begin
        lane_nxt[k].x = lane_i[k].x + (lane_i[k].y >>> IDX);
        lane_nxt[k].y = lane_i[k].y - (lane_i[k].x >>> IDX);
        lane_nxt[k].acc = lane_i[k].acc + atan_entry(IDX);
      end else begin
        lane_nxt[k].x = lane_i[k].x - (lane_i[k].y >>> IDX);
        lane_nxt[k].y = lane_i[k].y + (lane_i[k].x >>> IDX);
        lane_nxt[k].acc = lane_i[k].acc - atan_entry(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// ===== hdl/q2e_div_cell.sv =====
// One restoring-division cell: one quotient bit per enabled cycle.
// Depends on q2e_pkg.
module q2e_div_cell import q2e_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [DIV_W-1:0] den_i,
  input  logic [Q_W-1:0]   quo_i,
  output logic [DIV_W-1:0] rem_o,
  output logic [DIV_W-1:0] den_o,
  output logic [Q_W-1:0]   quo_o
);

  logic [DIV_W:0]   shl;
  logic [DIV_W-1:0] rem_r, rem_nxt, den_r;
  logic [Q_W-1:0]   quo_r, quo_nxt;

  always_comb begin
    shl = {rem_i, 1'b0};
    if (shl >= {1'b0, den_i}) begin
      rem_nxt = DIV_W'(shl - {1'b0, den_i});
      quo_nxt = {quo_i[Q_W-2:0], 1'b1};
    end else begin
      rem_nxt = shl[DIV_W-1:0];
      quo_nxt = {quo_i[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule

// ===== hdl/q2e_sqrt_cell.sv =====
// Digit-by-digit square root cell: settle one result bit per enabled cycle.
// Depends on q2e_pkg.
module q2e_sqrt_cell import q2e_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] val_i,
  input  logic [SQ_W-1:0] res_i,
  output logic [SQ_W-1:0] val_o,
  output logic [SQ_W-1:0] res_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * IDX);

  logic [SQ_W-1:0] val_r, val_nxt, res_r, res_nxt;
  logic [SQ_W:0]   trial;

  always_comb begin
    trial = {1'b0, res_i} + {1'b0, BIT};
    if ({1'b0, val_i} >= trial) begin
      val_nxt = val_i - SQ_W'(trial);
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      val_nxt = val_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      res_r <= res_nxt;
    end
  end

  assign val_o = val_r;
  assign res_o = res_r;

endmodule

// ===== hdl/quaternion_to_euler_angles.sv =====
// Quaternion to roll/pitch/heading converter, fully pipelined chain of cells.
// Stages in order: products, sums, divider, round, square, sqrt, pre-rotation, CORDIC, output.
// Throughput: one item per cycle; the whole chain advances while the output
// register is free or being taken, and holds otherwise.
// Reset (rst_n, synchronous, active low) clears only the valid bits.
module quaternion_to_euler_angles import q2e_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int unsigned ANGLE_FRACTION_BITS = ANGLE_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_deg[15:0], pitch_deg[30:16], heading_deg[46:31], 0
  output logic [1:0]  out_tuser   // invalid, pitch_clipped
);

  // Pipeline depth; all stages move together under a single advance enable.
  localparam int unsigned NDIV = Q_W;                // quotient bits incl. round bit
  localparam int unsigned NSQ = SQ_W / 2;            // sqrt cells
  localparam int unsigned DEPTH = 2 + NDIV + 2 + NSQ + 2 + CORDIC_STAGES;

  logic adv;
  logic in_fire;
  logic [DEPTH-1:0] vld_r;

  // Advance whenever the output register is empty or being taken; hold
  // every stage otherwise, so nothing in flight is ever dropped.
  assign adv = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = adv;
  assign in_fire = in_tvalid && adv;

  // ---------------- stage 0: products ----------------
  logic signed [15:0] w, x, y, z;
  assign w = in_tdata[15:0];
  assign x = in_tdata[31:16];
  assign y = in_tdata[47:32];
  assign z = in_tdata[63:48];

  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, wx_r, yz_r, wz_r, xy_r, wy_r, xz_r;
  logic zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ww_r <= w * w; xx_r <= x * x; yy_r <= y * y; zz_r <= z * z;
      wx_r <= w * x; yz_r <= y * z; wz_r <= w * z; xy_r <= x * y;
      wy_r <= w * y; xz_r <= x * z;
      zero_r <= (w == 0) && (x == 0) && (y == 0) && (z == 0);
    end
  end

  // ---------------- stage 1: sums ----------------
  logic [33:0] n2_r;
  logic [33:0] mag_r;
  logic sneg_r, zero1_r;
  cval_t rx_r, ry_r, hx_r, hy_r;
  logic signed [34:0] sn;

  assign sn = 35'(2) * (35'(wy_r) - 35'(xz_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      n2_r <= 34'(ww_r) + 34'(xx_r) + 34'(yy_r) + 34'(zz_r);
      mag_r <= sn[34] ? 34'(-sn) : 34'(sn);
      sneg_r <= sn[34];
      zero1_r <= zero_r;
      ry_r <= CW'(35'(2) * (35'(wx_r) + 35'(yz_r)));
      rx_r <= CW'(35'(ww_r) + 35'(zz_r) - 35'(xx_r) - 35'(yy_r));
      hy_r <= CW'(35'(2) * (35'(wz_r) + 35'(xy_r)));
      hx_r <= CW'(35'(ww_r) + 35'(xx_r) - 35'(yy_r) - 35'(zz_r));
    end
  end

  // ---------------- divider chain: q = round(mag*2^30 / n2) ----------------
  // mag <= n2, so NDIV cells give floor(mag*2^31 / n2); at mag == n2 every
  // bit comes out one, which still rounds to exactly one below.
  typedef struct packed {
    logic sneg;
    logic zero;
    cval_t rx, ry, hx, hy;
  } side_t;

  side_t side_d [NDIV+1];
  logic [DIV_W-1:0] rem_d [NDIV+1];
  logic [DIV_W-1:0] den_d [NDIV+1];
  logic [Q_W-1:0]   quo_d [NDIV+1];

  assign rem_d[0] = mag_r;
  assign den_d[0] = n2_r;
  assign quo_d[0] = '0;
  assign side_d[0] = '{sneg: sneg_r, zero: zero1_r, rx: rx_r, ry: ry_r, hx: hx_r, hy: hy_r};

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    q2e_div_cell u_div (
      .clk  (clk),
      .en   (adv),
      .rem_i(rem_d[g]),
      .den_i(den_d[g]),
      .quo_i(quo_d[g]),
      .rem_o(rem_d[g+1]),
      .den_o(den_d[g+1]),
      .quo_o(quo_d[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        side_d[g+1] <= side_d[g];
      end
    end
  end

  // ---------------- round, clip, square ----------------
  // Round half up from the extra quotient bit; a result of one or more clips.
  logic [Q_W-1:0] q31;
  logic [Q_W:0]   qr;
  logic [Q_W-1:0] q_r;
  logic clip_r;
  side_t side_q;

  assign q31 = quo_d[NDIV];
  assign qr = ({1'b0, q31} + (Q_W+1)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q <= side_d[NDIV];
      if (side_d[NDIV].zero || den_d[NDIV] == '0) begin
        q_r <= '0;
        clip_r <= 1'b0;
      end else if (qr >= (Q_W+1)'(1 << 30)) begin
        q_r <= Q_W'(1 << 30);
        clip_r <= 1'b1;
      end else begin
        q_r <= qr[Q_W-1:0];
        clip_r <= 1'b0;
      end
    end
  end

  logic [SQ_W-1:0] sq_r;
  logic [Q_W-1:0] q2_r;
  logic clip2_r;
  side_t side_s;
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= (SQ_W'(1) << 60) - SQ_W'(q_r) * SQ_W'(q_r);
      q2_r <= q_r;
      clip2_r <= clip_r;
      side_s <= side_q;
    end
  end

  // ---------------- square root chain ----------------
  logic [SQ_W-1:0] sv_d [NSQ+1];
  logic [SQ_W-1:0] sr_d [NSQ+1];
  logic [Q_W-1:0]  sq_q [NSQ+1];
  logic            sq_c [NSQ+1];
  side_t           sq_s [NSQ+1];
  assign sv_d[0] = sq_r;
  assign sr_d[0] = '0;
  assign sq_q[0] = q2_r;
  assign sq_c[0] = clip2_r;
  assign sq_s[0] = side_s;

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    q2e_sqrt_cell #(.IDX(g)) u_sq (
      .clk  (clk),
      .en   (adv),
      .val_i(sv_d[g]),
      .res_i(sr_d[g]),
      .val_o(sv_d[g+1]),
      .res_o(sr_d[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_q[g+1] <= sq_q[g];
        sq_c[g+1] <= sq_c[g];
        sq_s[g+1] <= sq_s[g];
      end
    end
  end

  // ---------------- pre-rotation into CORDIC range ----------------
  function automatic lane_t prerot(input cval_t xi, input cval_t yi);
    lane_t l;
    l.acc = '0;
    l.x = xi;
    l.y = yi;
    if (xi[CW-1]) begin
      if (!yi[CW-1]) begin
        l.x = yi; l.y = -xi; l.acc = ACC_W'(90) <<< ACC_FRAC;
      end else begin
        l.x = -yi; l.y = xi; l.acc = -(ACC_W'(90) <<< ACC_FRAC);
      end
    end
    return l;
  endfunction

  lane_t cl_d [CORDIC_STAGES+1][3];
  logic zero_c [CORDIC_STAGES+1];
  logic clip_c [CORDIC_STAGES+1];
  logic rz_c [CORDIC_STAGES+1];
  logic hz_c [CORDIC_STAGES+1];
  cval_t py;

  assign py = sq_s[NSQ].sneg ? -cval_t'(sq_q[NSQ]) : cval_t'(sq_q[NSQ]);

  always_ff @(posedge clk) begin
    if (adv) begin
      cl_d[0][0] <= prerot(sq_s[NSQ].rx, sq_s[NSQ].ry);
      cl_d[0][1] <= prerot(cval_t'(sr_d[NSQ]), py);
      cl_d[0][2] <= prerot(sq_s[NSQ].hx, sq_s[NSQ].hy);
      zero_c[0] <= sq_s[NSQ].zero;
      clip_c[0] <= sq_c[NSQ];
      rz_c[0] <= (sq_s[NSQ].rx == '0) && (sq_s[NSQ].ry == '0);
      hz_c[0] <= (sq_s[NSQ].hx == '0) && (sq_s[NSQ].hy == '0);
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    q2e_cordic_cell #(.IDX(g)) u_cc (
      .clk   (clk),
      .en    (adv),
      .lane_i(cl_d[g]),
      .lane_o(cl_d[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        zero_c[g+1] <= zero_c[g];
        clip_c[g+1] <= clip_c[g];
        rz_c[g+1] <= rz_c[g];
        hz_c[g+1] <= hz_c[g];
      end
    end
  end

  // ---------------- round and clamp ----------------
  localparam int unsigned SH = ACC_FRAC - ANGLE_FRACTION_BITS;
  localparam acc_t LIM180 = acc_t'(180) <<< ANGLE_FRACTION_BITS;
  localparam acc_t LIM90 = acc_t'(90) <<< ANGLE_FRACTION_BITS;

  function automatic acc_t fin(input acc_t a, input acc_t lim);
    acc_t r;
    r = (a + (acc_t'(1) <<< (SH - 1))) >>> SH;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic [47:0] res_data;
  logic [1:0]  res_user;
  acc_t ra, pa, ha;
  always_comb begin
    ra = rz_c[CORDIC_STAGES] ? '0 : fin(cl_d[CORDIC_STAGES][0].acc, LIM180);
    pa = fin(cl_d[CORDIC_STAGES][1].acc, LIM90);
    ha = hz_c[CORDIC_STAGES] ? '0 : fin(cl_d[CORDIC_STAGES][2].acc, LIM180);
    if (zero_c[CORDIC_STAGES]) begin
      ra = '0; pa = '0; ha = '0;
    end
    res_data = {1'b0, ha[15:0], pa[14:0], ra[15:0]};
    res_user = {clip_c[CORDIC_STAGES] && !zero_c[CORDIC_STAGES], zero_c[CORDIC_STAGES]};
  end

  // ---------------- valid chain and output register ----------------
  logic [47:0] out_data_r;
  logic [1:0]  out_user_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_data;
      out_user_r <= res_user;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_fire};
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

// ===== tb/sv/quaternion_to_euler_angles_tb.sv =====
// Self-checking testbench for quaternion_to_euler_angles.
// Predicts roll, pitch and heading with a local integer CORDIC model and
// compares every output item in order; depends on q2e_pkg and the RTL only.
module quaternion_to_euler_angles_tb import q2e_pkg::*;;

  localparam int STAGES = 16;
  localparam int AFB = 7;
  localparam int LATENCY = 84;
  localparam int N_RANDOM = 400;

  typedef struct packed {
    logic [14:0] pitch;
    logic [15:0] roll;
    logic [15:0] heading;
    logic invalid;
    logic clipped;
  } angles_t;

  // atan(2^-i) in 2^-24 degree, typed here for the predictor
  function automatic longint atan_step(input int i);
    return longint'(atan_entry(i));
  endfunction

  // Floor shift for signed values
  function automatic longint floor_shr(input longint v, input int k);
    return v >>> k;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(input longint yi, input longint xi,
                                          input longint lim);
    longint x, y, acc, t, dx, dy, r;
    x = xi;
    y = yi;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    // pre-rotate left half-plane by 90 degrees
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 64'sd90 <<< 24;
      end else begin
        t = x; x = -y; y = t; acc = -(64'sd90 <<< 24);
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = floor_shr(x, i);
      dy = floor_shr(y, i);
      if (y >= 0) begin
        x += dy; y -= dx; acc += atan_step(i);
      end else begin
        x -= dy; y += dx; acc -= atan_step(i);
      end
    end
    r = floor_shr(acc + (64'sd1 <<< (23 - AFB)), 24 - AFB);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_from_quat(input logic [63:0] q);
    longint w, x, y, z, ww, xx, yy, zz, sn, r, p, h;
    longint unsigned n2, mag, qt, c, one;
    angles_t a;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    a = '0;
    one = 64'd1 << 30;
    if (w == 0 && x == 0 && y == 0 && z == 0) begin
      a.invalid = 1'b1;
      return a;
    end
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    n2 = ww + xx + yy + zz;
    sn = 2 * (w * y - x * z);
    mag = sn < 0 ? -sn : sn;
    qt = ((mag << 30) + (n2 >> 1)) / n2;
    if (qt >= one) begin
      qt = one;
      a.clipped = 1'b1;
    end
    c = root_floor(one * one - qt * qt);
    r = vector_angle(2 * (w * x + y * z), ww + zz - xx - yy, 180 << AFB);
    h = vector_angle(2 * (w * z + x * y), ww + xx - yy - zz, 180 << AFB);
    p = vector_angle(sn < 0 ? -longint'(qt) : longint'(qt), longint'(c), 90 << AFB);
    a.roll = r[15:0];
    a.pitch = p[14:0];
    a.heading = h[15:0];
    return a;
  endfunction

  class angle_scoreboard;
    angles_t pending[$];
    int errors;
    int matched;
    int clipped_seen;
    int invalid_seen;

    function void note_quat(input logic [63:0] q);
      pending.push_back(euler_from_quat(q));
    endfunction

    function void check_angles(input logic [47:0] d, input logic [1:0] u);
      angles_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item roll=%0d pitch=%0d heading=%0d", $time,
                 $signed(d[15:0]), $signed(d[30:16]), $signed(d[46:31]));
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.roll) begin
        $display("%0t: roll expected %0d actual %0d", $time, $signed(e.roll),
                 $signed(d[15:0]));
        errors++;
      end
      if (d[30:16] !== e.pitch) begin
        $display("%0t: pitch expected %0d actual %0d", $time, $signed(e.pitch),
                 $signed(d[30:16]));
        errors++;
      end
      if (d[46:31] !== e.heading) begin
        $display("%0t: heading expected %0d actual %0d", $time, $signed(e.heading),
                 $signed(d[46:31]));
        errors++;
      end
      if (d[47] !== 1'b0) begin
        $display("%0t: pad bit expected 0 actual %b", $time, d[47]);
        errors++;
      end
      if (u[0] !== e.invalid) begin
        $display("%0t: invalid expected %b actual %b", $time, e.invalid, u[0]);
        errors++;
      end
      if (u[1] !== e.clipped) begin
        $display("%0t: pitch_clipped expected %b actual %b", $time, e.clipped, u[1]);
        errors++;
      end
      matched++;
      if (e.clipped) clipped_seen++;
      if (e.invalid) invalid_seen++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0] out_tuser;

  angle_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_on = 1'b0;    // receiver forced off while set
  event hold_start;

  always #5 clk = ~clk;

  quaternion_to_euler_angles DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Hold the receiver off for a long stretch of cycles once triggered
  always begin
    @(hold_start);
    hold_on <= 1'b1;
    repeat (300) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Sample the result channel and draw the next ready at the same edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_angles(out_tdata, out_tuser);
    if (hold_on) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one quaternion, with random idle cycles first; hold until taken
  task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_quat({z, y, x, w});
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    drop_valid();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_component();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(32)) - 16);
      3: return 16'($urandom_range(16384));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [15:0] c[4];
    int k;
    for (int n = 0; n < count; n++) begin
      foreach (c[i]) c[i] = rand_component();
      // sometimes zero out components to hit gimbal lock and clipping
      if ($urandom_range(7) == 0) c[$urandom_range(3)] = '0;
      if ($urandom_range(15) == 0) begin
        k = $urandom_range(3);
        foreach (c[i]) if (i != k) c[i] = '0;
      end
      send_quat(c[0], c[1], c[2], c[3]);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero, axis extremes, clipping and gimbal lock
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quat(16'h2D41, 16'h0000, 16'h2D41, 16'h0000);
    send_quat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);
    send_quat(16'h2D41, 16'h2D41, 16'h0000, 16'h0000);
    send_quat(16'h2D41, 16'hD2BF, 16'h0000, 16'h0000);
    send_quat(16'h2D41, 16'h0000, 16'h0000, 16'hD2BF);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001);
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_quat(16'h2000, 16'h2000, 16'h2000, 16'hE000);

    // Long receiver stall while items keep coming: pipeline fills, input stalls
    -> hold_start;
    send_random(120);
    drain_results();   // sender waits for every result

    send_idle_pct = 31; recv_idle_pct = 88;
    send_random(100);
    send_idle_pct = 88; recv_idle_pct = 31;
    send_random(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(N_RANDOM - 320);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Checked %0d results: %0d with invalid input, %0d with clipped pitch,",
             board.matched, board.invalid_seen, board.clipped_seen);
    $display("under idle and stall mixes on both channels incl. a full pipeline.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("quaternion_to_euler_angles regression: pass");
    end else begin
      $display("quaternion_to_euler_angles regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("quaternion_to_euler_angles regression: fail");
    $finish;
  end

endmodule
